>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// Needs clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising edge of clk, off while rst is high.
`define SQT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, same clocking and reset.
`define SQT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sqt_pkg.sv
// Shared types, codes and constants of the shell quote tokenizer.
// No dependencies.
package sqt_pkg;

  localparam int MAX_WORDS = 128;
  localparam int WC_W      = $clog2(MAX_WORDS);
  localparam int IDX_W     = 7;
  localparam int IDX_EXT_W = (WC_W > IDX_W) ? WC_W : IDX_W;
  localparam logic [WC_W-1:0] MAX_IDX = WC_W'(MAX_WORDS - 1);

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_WEND = 2'd1;
  localparam logic [1:0] KIND_LEND = 2'd2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BTICK  = 8'h60;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_out;
    logic [IDX_W-1:0] word_index;
  } result_t;

  typedef struct packed {
    result_t [2:0] slot;
    logic          too_many;
    logic [1:0]    count;
  } bundle_t;

  function automatic logic [IDX_W-1:0] to_idx(input logic [WC_W-1:0] v);
    logic [IDX_EXT_W-1:0] e;
    e = IDX_EXT_W'(v);
    return e[IDX_W-1:0];
  endfunction

endpackage

>>> src/sqt_in_if.sv
// Input channel: one command line byte or end of line per transaction.
// No dependencies.
interface sqt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_end;

  modport source (output valid, output char_in, output is_end, input ready);
  modport sink (input valid, input char_in, input is_end, output ready);
endinterface

>>> src/sqt_out_if.sv
// Output channel: one token result per transaction.
// No dependencies.
interface sqt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic [6:0] word_index;
  logic       too_many;
  logic       last;

  modport source (output valid, output kind, output char_out, output word_index,
                  output too_many, output last, input ready);
  modport sink (input valid, input kind, input char_out, input word_index,
                input too_many, input last, output ready);
endinterface

>>> src/sqt_parser.sv
// Quoting state machine: holds the line state and builds the result bundle
// of the current input. Depends on sqt_pkg.
module sqt_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       char_in,
  input  logic             is_end,
  output sqt_pkg::bundle_t bundle
);

  logic                     in_word, in_single, in_double, esc_p, esc_d;
  logic                     had_word, overflowed;
  logic [sqt_pkg::WC_W-1:0] word_count;

  logic                     in_word_next, in_single_next, in_double_next;
  logic                     esc_p_next, esc_d_next, had_word_next, overflowed_next;
  logic [sqt_pkg::WC_W-1:0] word_count_next;

  logic                        beg;
  logic [sqt_pkg::IDX_W-1:0]   widx, lidx;
  logic [sqt_pkg::WC_W-1:0]    words;
  sqt_pkg::result_t            byte_c, byte_bs, wend, lend;

  always_comb begin
    beg = !is_end && !esc_p && !esc_d && !in_single && !in_double &&
          (char_in != sqt_pkg::CH_SPACE) && !in_word;

    word_count_next = word_count;
    overflowed_next = overflowed;
    if (beg && had_word) begin
      if (word_count < sqt_pkg::MAX_IDX) begin
        word_count_next = word_count + sqt_pkg::WC_W'(1);
      end else begin
        overflowed_next = 1'b1;
      end
    end

    widx = sqt_pkg::to_idx(word_count_next);
    if (!had_word) begin
      words = '0;
    end else if (word_count == sqt_pkg::MAX_IDX) begin
      words = word_count;
    end else begin
      words = word_count + sqt_pkg::WC_W'(1);
    end
    lidx = sqt_pkg::to_idx(words);

    byte_c  = '{kind: sqt_pkg::KIND_BYTE, char_out: char_in, word_index: widx};
    byte_bs = '{kind: sqt_pkg::KIND_BYTE, char_out: sqt_pkg::CH_BSLASH, word_index: widx};
    wend    = '{kind: sqt_pkg::KIND_WEND, char_out: 8'h00, word_index: widx};
    lend    = '{kind: sqt_pkg::KIND_LEND, char_out: 8'h00, word_index: lidx};

    in_word_next   = in_word;
    in_single_next = in_single;
    in_double_next = in_double;
    esc_p_next     = esc_p;
    esc_d_next     = esc_d;
    had_word_next  = had_word;

    bundle.slot     = {byte_c, byte_c, byte_c};
    bundle.too_many = overflowed_next;
    bundle.count    = 2'd0;

    if (is_end) begin
      if (in_word) begin
        if (esc_d) begin
          bundle.slot[0] = byte_bs;
          bundle.slot[1] = wend;
          bundle.slot[2] = lend;
          bundle.count   = 2'd3;
        end else begin
          bundle.slot[0] = wend;
          bundle.slot[1] = lend;
          bundle.count   = 2'd2;
        end
      end else begin
        bundle.slot[0] = lend;
        bundle.count   = 2'd1;
      end
      in_word_next    = 1'b0;
      in_single_next  = 1'b0;
      in_double_next  = 1'b0;
      esc_p_next      = 1'b0;
      esc_d_next      = 1'b0;
      had_word_next   = 1'b0;
      word_count_next = '0;
      overflowed_next = 1'b0;
    end else if (esc_p) begin
      esc_p_next   = 1'b0;
      bundle.count = 2'd1;
    end else if (esc_d) begin
      esc_d_next = 1'b0;
      if (char_in == sqt_pkg::CH_DQUOTE || char_in == sqt_pkg::CH_BSLASH ||
          char_in == sqt_pkg::CH_DOLLAR || char_in == sqt_pkg::CH_BTICK) begin
        bundle.count = 2'd1;
      end else begin
        bundle.slot[0] = byte_bs;
        bundle.count   = 2'd2;
      end
    end else if (in_single) begin
      if (char_in == sqt_pkg::CH_SQUOTE) begin
        in_single_next = 1'b0;
      end else begin
        bundle.count = 2'd1;
      end
    end else if (in_double) begin
      if (char_in == sqt_pkg::CH_DQUOTE) begin
        in_double_next = 1'b0;
      end else if (char_in == sqt_pkg::CH_BSLASH) begin
        esc_d_next = 1'b1;
      end else begin
        bundle.count = 2'd1;
      end
    end else if (char_in == sqt_pkg::CH_SPACE) begin
      if (in_word) begin
        bundle.slot[0] = wend;
        bundle.count   = 2'd1;
        in_word_next   = 1'b0;
      end
    end else begin
      if (beg) begin
        had_word_next = 1'b1;
        in_word_next  = 1'b1;
      end
      if (char_in == sqt_pkg::CH_SQUOTE) begin
        in_single_next = 1'b1;
      end else if (char_in == sqt_pkg::CH_DQUOTE) begin
        in_double_next = 1'b1;
      end else if (char_in == sqt_pkg::CH_BSLASH) begin
        esc_p_next = 1'b1;
      end else begin
        bundle.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word    <= 1'b0;
      in_single  <= 1'b0;
      in_double  <= 1'b0;
      esc_p      <= 1'b0;
      esc_d      <= 1'b0;
      had_word   <= 1'b0;
      overflowed <= 1'b0;
      word_count <= '0;
    end else if (take) begin
      in_word    <= in_word_next;
      in_single  <= in_single_next;
      in_double  <= in_double_next;
      esc_p      <= esc_p_next;
      esc_d      <= esc_d_next;
      had_word   <= had_word_next;
      overflowed <= overflowed_next;
      word_count <= word_count_next;
    end
  end

endmodule

>>> src/sqt_serializer.sv
// Result register: holds one bundle and hands out its results one per
// transaction. Depends on sqt_pkg.
module sqt_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  sqt_pkg::bundle_t bundle,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output sqt_pkg::result_t res,
  output logic             too_many,
  output logic             last
);

  sqt_pkg::bundle_t held;
  logic             full;
  logic [1:0]       ptr;
  logic             fire;

  assign res       = held.slot[ptr];
  assign too_many  = held.too_many;
  assign last      = (ptr == held.count - 2'd1);
  assign out_valid = full;
  assign fire      = full && out_ready;
  assign can_take  = !full || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      ptr  <= 2'd0;
    end else if (take && bundle.count != 2'd0) begin
      full <= 1'b1;
      ptr  <= 2'd0;
    end else if (fire) begin
      if (last) begin
        full <= 1'b0;
        ptr  <= 2'd0;
      end else begin
        ptr <= ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && bundle.count != 2'd0) begin
      held <= bundle;
    end
  end

endmodule

>>> src/shell_quote_tokenizer_unit.sv
// Shell quote tokenizer: splits a byte stream into words by shell quoting.
// Latency: first result of an input is valid the cycle after its transaction.
// Throughput: one input per cycle unless the output stalls; n results (up to 3)
// hold the result register until all are taken, and none leave it free.
// Reset: synchronous on rst, clears the line state and drops pending results.
module shell_quote_tokenizer_unit (
  input  logic      clk,
  input  logic      rst,
  sqt_in_if.sink    line,
  sqt_out_if.source tokens
);

  logic             take;
  logic             can_take;
  sqt_pkg::bundle_t bundle;
  sqt_pkg::result_t res;

  assign line.ready = can_take;
  assign take       = line.valid && can_take;

  sqt_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .char_in (line.char_in),
    .is_end  (line.is_end),
    .bundle  (bundle)
  );

  sqt_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .bundle    (bundle),
    .can_take  (can_take),
    .out_valid (tokens.valid),
    .out_ready (tokens.ready),
    .res       (res),
    .too_many  (tokens.too_many),
    .last      (tokens.last)
  );

  assign tokens.kind       = res.kind;
  assign tokens.char_out   = res.char_out;
  assign tokens.word_index = res.word_index;

endmodule

>>> src/sqt_checker.sv
// Port-level checks of the tokenizer, bound to the top level.
// Depends on assert_macros.svh and sqt_pkg.
`include "assert_macros.svh"

module sqt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] char_out,
  input logic [6:0] word_index,
  input logic       too_many,
  input logic       last
);

  logic [18:0] payload;
  logic        is_byte;
  logic        known_kind;

  assign payload    = {kind, char_out, word_index, too_many, last};
  assign is_byte    = (kind == sqt_pkg::KIND_BYTE);
  assign known_kind = is_byte || (kind == sqt_pkg::KIND_WEND) || (kind == sqt_pkg::KIND_LEND);

  `SQT_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SQT_ASSERT_NEXT(a_payload_held, out_valid && !out_ready, $stable(payload), "payload changed")
  `SQT_ASSERT(a_lend_last, !(out_valid && kind == sqt_pkg::KIND_LEND) || last, "line end not last")
  `SQT_ASSERT(a_char_zero, !(out_valid && !is_byte) || char_out == 8'h00, "marker carries a byte")
  `SQT_ASSERT(a_kind_code, !out_valid || known_kind, "unknown result kind")

endmodule

bind shell_quote_tokenizer_unit sqt_checker u_sqt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .kind       (tokens.kind),
  .char_out   (tokens.char_out),
  .word_index (tokens.word_index),
  .too_many   (tokens.too_many),
  .last       (tokens.last)
);
